// ===== sv/bctd_pkg.sv =====
// Package for the BC1/BC2/BC3 block decoder: payload structs, format codes,
// pipeline stage records and the constant dividers. No dependencies.
`default_nettype none

package bctd_pkg;

    typedef enum logic [1:0] {
        FMT_DXT1  = 2'd0,
        FMT_DXT1A = 2'd1,
        FMT_DXT3  = 2'd2,
        FMT_DXT5  = 2'd3
    } fmt_t;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } in_t;

    typedef struct packed {
        logic [1:0]  row_index;
        logic [31:0] texel_0;
        logic [31:0] texel_1;
        logic [31:0] texel_2;
        logic [31:0] texel_3;
        logic        last_row;
    } out_t;

    // endpoints expanded, weighted sums formed
    typedef struct packed {
        fmt_t              fmt;
        logic [63:0]       lo;
        logic [31:0]       idx;
        logic [2:0][7:0]   p0;
        logic [2:0][7:0]   p1;
        logic              four;
        logic [2:0][9:0]   sum2;
        logic [2:0][9:0]   sum3;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic              agt;
        logic [5:0][10:0]  asum;
    } st2_t;

    // full palettes, ready for row emission
    typedef struct packed {
        fmt_t              fmt;
        logic [63:0]       lo;
        logic [31:0]       idx;
        logic [3:0][23:0]  pal;
        logic              three;
        logic [7:0][7:0]   alpha;
    } st3_t;

    localparam logic [9:0]  DIV3_MUL   = 10'd683;
    localparam int          DIV3_SHIFT = 11;
    localparam logic [11:0] DIV5_MUL   = 12'd3277;
    localparam logic [11:0] DIV7_MUL   = 12'd2341;
    localparam int          DIV57_SHIFT = 14;

    // floor(s/3) for s <= 765
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] prod;
        prod = 20'(s) * 20'(DIV3_MUL);
        return prod[DIV3_SHIFT +: 8];
    endfunction

    // floor(s/5) for s <= 1275
    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [21:0] prod;
        prod = 22'(s) * 22'(DIV5_MUL);
        return prod[DIV57_SHIFT +: 8];
    endfunction

    // floor(s/7) for s <= 1785
    function automatic logic [7:0] div7(input logic [10:0] s);
        logic [21:0] prod;
        prod = 22'(s) * 22'(DIV7_MUL);
        return prod[DIV57_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/bc_texture_block_decoder_top.sv =====
// BC1/BC2/BC3 (DXT1/DXT3/DXT5) 4x4 block decoder, top level.
// Depends on bctd_pkg.
//
// Usage:
//  - s_valid/s_ready/s_data: one compressed block per request, block bytes
//    0..7 in block_low and 8..15 in block_high, both little-endian.
//  - m_valid/m_ready/m_data: four row requests per block, top row first,
//    texels packed R[7:0] G[15:8] B[23:16] A[31:24]; last_row marks row 3.
//  - cfg_valid/cfg_ready/cfg_data: block_format register, always ready.
//    Write it only while no block is in flight; each block samples it on
//    entry.
//  - Throughput: the output register emits one row per cycle while m_ready is
//    high, four rows per block. Two more blocks buffer in the upper stages.
//  - Pipeline: entry register, endpoint expand and weighted sums, constant
//    dividers into the palette, then row select into the output register.
//  - Stall: while m_ready is low the output row holds, the stages fill, and
//    s_ready drops once the entry stage is occupied. Nothing is dropped.
//  - Reset (aresetn low, synchronous): all stages empty, row counter at the
//    top row, block_format back to DXT1.
`default_nettype none

module bc_texture_block_decoder_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    input  wire logic [1:0]    cfg_data,
    input  wire logic          s_valid,
    output      logic          s_ready,
    input  wire bctd_pkg::in_t s_data,
    output      logic          m_valid,
    input  wire logic          m_ready,
    output      bctd_pkg::out_t m_data
);
    import bctd_pkg::*;

    fmt_t        fmt_reg;

    logic        s1_valid_reg;
    fmt_t        s1_fmt_reg;
    logic [63:0] s1_lo_reg;
    logic [63:0] s1_hi_reg;

    logic        s2_valid_reg;
    st2_t        s2_reg;
    st2_t        s2_next;

    logic        s3_valid_reg;
    st3_t        s3_reg;
    st3_t        s3_next;

    logic [1:0]  row_reg;
    logic        m_valid_reg;
    out_t        m_data_reg;
    out_t        m_data_next;

    logic        s1_take;
    logic        s2_take;
    logic        s3_take;
    logic        out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_DXT1;
        end else if (cfg_valid) begin
            fmt_reg <= fmt_t'(cfg_data);
        end
    end

    // stage advance
    assign out_load = s3_valid_reg && (!m_valid_reg || m_ready);
    assign s3_take  = !s3_valid_reg || (out_load && row_reg == 2'd3);
    assign s2_take  = !s2_valid_reg || s3_take;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign s_ready  = s1_take;

    // stage 1: entry register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_take) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take && s_valid) begin
            s1_fmt_reg <= fmt_reg;
            s1_lo_reg  <= s_data.block_low;
            s1_hi_reg  <= s_data.block_high;
        end
    end

    // stage 1 -> 2: expand endpoints, form weighted sums
    always_comb begin
        logic        is_dxt1;
        logic [63:0] color;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [10:0] sgt;
        logic [10:0] sle;
        is_dxt1 = (s1_fmt_reg == FMT_DXT1) || (s1_fmt_reg == FMT_DXT1A);
        color   = is_dxt1 ? s1_lo_reg : s1_hi_reg;
        c0      = color[15:0];
        c1      = color[31:16];
        s2_next.fmt  = s1_fmt_reg;
        s2_next.lo   = s1_lo_reg;
        s2_next.idx  = color[63:32];
        s2_next.p0[0] = {c0[15:11], c0[15:13]};
        s2_next.p0[1] = {c0[10:5], c0[10:9]};
        s2_next.p0[2] = {c0[4:0], c0[4:2]};
        s2_next.p1[0] = {c1[15:11], c1[15:13]};
        s2_next.p1[1] = {c1[10:5], c1[10:9]};
        s2_next.p1[2] = {c1[4:0], c1[4:2]};
        s2_next.four = !is_dxt1 || (c0 > c1);
        for (int ch = 0; ch < 3; ch++) begin
            if (s2_next.four) begin
                s2_next.sum2[ch] = {1'b0, s2_next.p0[ch], 1'b0} + 10'(s2_next.p1[ch]);
                s2_next.sum3[ch] = 10'(s2_next.p0[ch]) + {1'b0, s2_next.p1[ch], 1'b0};
            end else begin
                s2_next.sum2[ch] = 10'(s2_next.p0[ch]) + 10'(s2_next.p1[ch]);
                s2_next.sum3[ch] = '0;
            end
        end
        s2_next.a0  = s1_lo_reg[7:0];
        s2_next.a1  = s1_lo_reg[15:8];
        s2_next.agt = s2_next.a0 > s2_next.a1;
        for (int k = 0; k < 6; k++) begin
            sgt = 11'(s2_next.a0) * 11'(6 - k) + 11'(s2_next.a1) * 11'(k + 1);
            sle = 11'(s2_next.a0) * 11'(4 - k) + 11'(s2_next.a1) * 11'(k + 1);
            if (s2_next.agt) begin
                s2_next.asum[k] = sgt;
            end else if (k < 4) begin
                s2_next.asum[k] = sle;
            end else begin
                s2_next.asum[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_take) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_take && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    // stage 2 -> 3: constant dividers build the palettes
    always_comb begin
        s3_next.fmt   = s2_reg.fmt;
        s3_next.lo    = s2_reg.lo;
        s3_next.idx   = s2_reg.idx;
        s3_next.three = !s2_reg.four;
        s3_next.pal[0] = s2_reg.p0;
        s3_next.pal[1] = s2_reg.p1;
        for (int ch = 0; ch < 3; ch++) begin
            if (s2_reg.four) begin
                s3_next.pal[2][8*ch +: 8] = div3(s2_reg.sum2[ch]);
                s3_next.pal[3][8*ch +: 8] = div3(s2_reg.sum3[ch]);
            end else begin
                s3_next.pal[2][8*ch +: 8] = s2_reg.sum2[ch][8:1];
                s3_next.pal[3][8*ch +: 8] = '0;
            end
        end
        s3_next.alpha[0] = s2_reg.a0;
        s3_next.alpha[1] = s2_reg.a1;
        for (int k = 0; k < 6; k++) begin
            if (s2_reg.agt) begin
                s3_next.alpha[k + 2] = div7(s2_reg.asum[k]);
            end else if (k < 4) begin
                s3_next.alpha[k + 2] = div5(s2_reg.asum[k]);
            end else if (k == 4) begin
                s3_next.alpha[k + 2] = 8'd0;
            end else begin
                s3_next.alpha[k + 2] = 8'd255;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_take) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_take && s2_valid_reg) begin
            s3_reg <= s3_next;
        end
    end

    // stage 3 -> output: one row of texels per cycle while the output is not stalled
    always_comb begin
        logic [3:0]       ti;
        logic [4:0]       off_idx;
        logic [5:0]       off_nib;
        logic [5:0]       off_acode;
        logic [1:0]       sel;
        logic [3:0]       nib;
        logic [2:0]       acode;
        logic [7:0]       a;
        logic [3:0][31:0] tex;
        for (int c = 0; c < 4; c++) begin
            ti        = {row_reg, 2'(c)};
            off_idx   = {ti, 1'b0};
            off_nib   = {ti, 2'b00};
            off_acode = 6'd16 + {1'b0, ti, 1'b0} + 6'(ti);
            sel       = s3_reg.idx[off_idx +: 2];
            nib       = s3_reg.lo[off_nib +: 4];
            acode     = s3_reg.lo[off_acode +: 3];
            case (s3_reg.fmt)
                FMT_DXT3: a = {nib, nib};
                FMT_DXT5: a = s3_reg.alpha[acode];
                default:  a = (s3_reg.three && sel == 2'd3) ? 8'd0 : 8'd255;
            endcase
            tex[c] = {a, s3_reg.pal[sel]};
        end
        m_data_next.row_index = row_reg;
        m_data_next.texel_0   = tex[0];
        m_data_next.texel_1   = tex[1];
        m_data_next.texel_2   = tex[2];
        m_data_next.texel_3   = tex[3];
        m_data_next.last_row  = (row_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            row_reg     <= 2'd0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                row_reg     <= row_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a block is mid-emission only while stage 3 still holds it
    a_row_needs_block: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg != 2'd0 |-> s3_valid_reg)
        else $error("row counter advanced without a block in stage 3");

    a_block_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && row_reg != 2'd3 |=> s3_valid_reg && $stable(s3_reg))
        else $error("block left stage 3 before its last row");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.last_row == (m_data_reg.row_index == 2'd3)))
        else $error("last_row flag does not match row index");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for bc_texture_block_decoder_top: directed and random DXT1/DXT3/DXT5 block
// requests, each row checked against an in-bench block decoder or a typed texel value.
// Depends on bctd_pkg and the decoder RTL.

module tb_top;
    import bctd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 56;

    typedef out_t [3:0] block_rows_t;

    typedef struct {
        fmt_t        fmt;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          typed;
        logic [31:0] texel;
    } dir_row_t;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = '0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_data    = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_data;

    out_t rows_due[$];
    out_t want_row;
    fmt_t cur_fmt = FMT_DXT1;
    int   mismatches = 0;
    int   idle_cycles = 0;

    // typed rows hold one texel value across the whole block
    dir_row_t dir_tab [21] = '{
        '{FMT_DXT1,  64'h0000000000000000, 64'h0000000000000000, 1'b1, 32'hFF000000},
        '{FMT_DXT1,  64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 1'b1, 32'h00000000},
        '{FMT_DXT1,  64'h000000000000FFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{FMT_DXT1,  64'h555555550000FFFF, 64'h0000000000000000, 1'b1, 32'hFF000000},
        '{FMT_DXT1,  64'hE4E4E4E41234F800, 64'h0000000000000000, 1'b0, 32'h0},
        '{FMT_DXT1,  64'hE4E4E4E4F8001234, 64'hA5A5A5A5A5A5A5A5, 1'b0, 32'h0},
        '{FMT_DXT1,  64'h1B1B1B1B7BEF7BEF, 64'h0000000000000000, 1'b0, 32'h0},
        '{FMT_DXT1A, 64'hE4E4E4E407E0F81F, 64'h0000000000000000, 1'b0, 32'h0},
        '{FMT_DXT1A, 64'hE4E4E4E4F81F07E0, 64'h0000000000000000, 1'b0, 32'h0},
        '{FMT_DXT1A, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'h00000000},
        '{FMT_DXT3,  64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 1'b1, 32'hFF000000},
        '{FMT_DXT3,  64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'h00FFFFFF},
        '{FMT_DXT3,  64'hFEDCBA9876543210, 64'hE4E4E4E4F81F07E0, 1'b0, 32'h0},
        '{FMT_DXT3,  64'h0123456789ABCDEF, 64'h1B1B1B1BAAAAAAAA, 1'b0, 32'h0},
        '{FMT_DXT5,  64'h0000000000000000, 64'h0000000000000000, 1'b1, 32'h00000000},
        '{FMT_DXT5,  64'h00000000000000FF, 64'h0000000000000000, 1'b1, 32'hFF000000},
        '{FMT_DXT5,  64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{FMT_DXT5,  64'hFFFFFFFFFFFF0000, 64'h0000000000000000, 1'b1, 32'hFF000000},
        '{FMT_DXT5,  64'hFAC688FAC68810F0, 64'hE4E4E4E4F800001F, 1'b0, 32'h0},
        '{FMT_DXT5,  64'hFAC688FAC688F010, 64'hE4E4E4E40000FFFF, 1'b0, 32'h0},
        '{FMT_DXT5,  64'hFAC688FAC6888080, 64'hE4E4E4E4FFFF0000, 1'b0, 32'h0}
    };

    bc_texture_block_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [23:0] rgb565_to_888(input logic [15:0] v);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = v[15:11];
        g6 = v[10:5];
        b5 = v[4:0];
        return {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
    endfunction

    function automatic logic [23:0] blend_rgb(input logic [23:0] x, input logic [23:0] y,
                                              input int wx, input int wy, input int dv);
        logic [23:0] res;
        int ch;
        int px;
        int py;
        for (ch = 0; ch < 3; ch++) begin
            px = x[8*ch +: 8];
            py = y[8*ch +: 8];
            res[8*ch +: 8] = 8'((px * wx + py * wy) / dv);
        end
        return res;
    endfunction

    function automatic block_rows_t decode_block(input in_t blk, input fmt_t f);
        block_rows_t rows;
        logic [63:0] color;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] sel;
        logic [31:0] pal [4];
        logic [31:0] tx  [4];
        int          ramp [8];
        int          a0;
        int          a1;
        int          k;
        int          r;
        int          c;
        int          i;
        bit          dxt1;
        dxt1  = (f == FMT_DXT1) || (f == FMT_DXT1A);
        color = dxt1 ? blk.block_low : blk.block_high;
        c0    = color[15:0];
        c1    = color[31:16];
        sel   = color[63:32];
        pal[0] = {8'hFF, rgb565_to_888(c0)};
        pal[1] = {8'hFF, rgb565_to_888(c1)};
        if (!dxt1 || c0 > c1) begin
            pal[2] = {8'hFF, blend_rgb(pal[0][23:0], pal[1][23:0], 2, 1, 3)};
            pal[3] = {8'hFF, blend_rgb(pal[0][23:0], pal[1][23:0], 1, 2, 3)};
        end else begin
            // three colors plus transparent black
            pal[2] = {8'hFF, blend_rgb(pal[0][23:0], pal[1][23:0], 1, 1, 2)};
            pal[3] = 32'h0;
        end
        a0 = blk.block_low[7:0];
        a1 = blk.block_low[15:8];
        ramp[0] = a0;
        ramp[1] = a1;
        if (a0 > a1) begin
            for (k = 0; k < 6; k++) ramp[k+2] = (a0 * (6 - k) + a1 * (k + 1)) / 7;
        end else begin
            for (k = 0; k < 4; k++) ramp[k+2] = (a0 * (4 - k) + a1 * (k + 1)) / 5;
            ramp[6] = 0;
            ramp[7] = 255;
        end
        for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
                i = 4 * r + c;
                tx[c] = pal[sel[2*i +: 2]];
                if (f == FMT_DXT3) begin
                    tx[c][31:24] = 8'(blk.block_low[4*i +: 4] * 17);
                end else if (f == FMT_DXT5) begin
                    tx[c][31:24] = 8'(ramp[blk.block_low[16 + 3*i +: 3]]);
                end
            end
            rows[r].row_index = 2'(r);
            rows[r].texel_0   = tx[0];
            rows[r].texel_1   = tx[1];
            rows[r].texel_2   = tx[2];
            rows[r].texel_3   = tx[3];
            rows[r].last_row  = (r == 3);
        end
        return rows;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer_block(input in_t blk, input block_rows_t want);
        int r;
        s_valid <= 1'b1;
        s_data  <= blk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        for (r = 0; r < 4; r++) rows_due.push_back(want[r]);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_format(input fmt_t f);
        s_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_fmt = f;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rows_due.size() == 0) begin
                $display("%t: row request with none expected, actual %h", $time, m_data);
                mismatches++;
            end else begin
                want_row = rows_due.pop_front();
                check_field("row_index", 32'(want_row.row_index), 32'(m_data.row_index));
                check_field("texel_0", want_row.texel_0, m_data.texel_0);
                check_field("texel_1", want_row.texel_1, m_data.texel_1);
                check_field("texel_2", want_row.texel_2, m_data.texel_2);
                check_field("texel_3", want_row.texel_3, m_data.texel_3);
                check_field("last_row", 32'(want_row.last_row), 32'(m_data.last_row));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int run;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        fmt_t        phase_fmt [4];
        in_t         blk;
        block_rows_t want;
        fmt_t        f;
        bit          burst;
        int          n;
        int          p;
        int          r;

        phase_fmt = '{FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_DXT1A};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first requests run on the reset format
        for (n = 0; n < $size(dir_tab); n++) begin
            if (dir_tab[n].fmt != cur_fmt) write_format(dir_tab[n].fmt);
            blk.block_low  = dir_tab[n].lo;
            blk.block_high = dir_tab[n].hi;
            if (dir_tab[n].typed) begin
                for (r = 0; r < 4; r++) begin
                    want[r].row_index = 2'(r);
                    want[r].texel_0   = dir_tab[n].texel;
                    want[r].texel_1   = dir_tab[n].texel;
                    want[r].texel_2   = dir_tab[n].texel;
                    want[r].texel_3   = dir_tab[n].texel;
                    want[r].last_row  = (r == 3);
                end
            end else begin
                want = decode_block(blk, cur_fmt);
            end
            offer_block(blk, want);
            idle_sender(pick_gap());
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            f = (p < 4) ? phase_fmt[p] : fmt_t'($urandom_range(0, 3));
            write_format(f);
            burst = (p == 2) || ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                blk.block_low  = {$urandom, $urandom};
                blk.block_high = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: begin
                        blk.block_low[31:16]  = blk.block_low[15:0];
                        blk.block_high[31:16] = blk.block_high[15:0];
                    end
                    1: blk.block_low[15:8] = blk.block_low[7:0];
                    default: ;
                endcase
                offer_block(blk, decode_block(blk, cur_fmt));
                if (p == 1 && n == 25) begin
                    // hold off until the pipeline has drained
                    s_valid <= 1'b0;
                    while (rows_due.size() != 0) @(posedge aclk);
                end else if (!burst) begin
                    idle_sender(pick_gap());
                end
            end
        end

        s_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bctd_pkg.sv
sv/bc_texture_block_decoder_top.sv
dv/tb_top.sv
